// ===== rtl/core/abad_pkg.sv =====
// Shared types and constants for the arcade bus address decoder.
package abad_pkg;

  localparam int unsigned RAM_DEPTH = 4096;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  // Bus access kinds, carried on in_tuser.
  typedef enum logic [1:0] {
    FUNC_FETCH    = 2'd0,
    FUNC_READ     = 2'd1,
    FUNC_WRITE    = 2'd2,
    FUNC_PORT_OUT = 2'd3
  } func_t;

  // Addresses after bit 15 has been dropped.
  localparam logic [2:0]  RAM_PAGE    = 3'b100;
  localparam logic [14:0] ADDR_IN0    = 15'h5000;
  localparam logic [14:0] ADDR_IN1    = 15'h5040;
  localparam logic [14:0] ADDR_DIP    = 15'h5080;
  localparam logic [14:0] ADDR_IRQ_EN = 15'h5000;
  localparam logic [14:0] ADDR_BOOT   = 15'h43CA;
  localparam logic [7:0]  BOOT_MARK   = 8'd80;
  localparam logic [7:0]  OPEN_BUS    = 8'hFF;

  typedef struct packed {
    logic              rom_hit;
    logic [15:0]       rom_address;
    logic              ram_read;
    logic [7:0]        read_const;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic              irq_en_we;
    logic              vec_we;
    logic              boot_set;
  } dec_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

endpackage

// ===== rtl/core/abad_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
module abad_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/abad_decode.sv =====
// Address decode of one bus access into memory, register and output controls.
module abad_decode (
  input  logic [1:0]     func,
  input  logic [15:0]    address,
  input  logic [7:0]     write_data,
  input  logic [6:0]     buttons,
  input  logic [7:0]     dip_switch,
  output abad_pkg::dec_t dec
);

  logic [14:0] a;
  logic [7:0]  port_a;
  logic [7:0]  port_b;
  logic        ram_page;

  assign a        = address[14:0];
  assign ram_page = (a[14:12] == abad_pkg::RAM_PAGE);

  // Active-low inputs; coin sits on bit 5 of the first port.
  assign port_a = {2'b11, ~buttons[4], 1'b1, ~buttons[3:0]};
  assign port_b = {2'b11, ~buttons[5], ~buttons[6], 4'hF};

  always_comb begin
    dec             = '0;
    dec.read_const  = abad_pkg::OPEN_BUS;
    dec.ram_addr    = a[abad_pkg::RAM_AW-1:0];
    case (abad_pkg::func_t'(func))
      abad_pkg::FUNC_FETCH: begin
        dec.rom_hit     = 1'b1;
        dec.rom_address = address;
      end
      abad_pkg::FUNC_READ: begin
        if (!a[14]) begin
          dec.rom_hit     = 1'b1;
          dec.rom_address = {1'b0, a};
        end else if (ram_page) begin
          dec.ram_read = 1'b1;
        end else if (a == abad_pkg::ADDR_DIP) begin
          dec.read_const = dip_switch;
        end else if (a == abad_pkg::ADDR_IN0) begin
          dec.read_const = port_a;
        end else if (a == abad_pkg::ADDR_IN1) begin
          dec.read_const = port_b;
        end
      end
      abad_pkg::FUNC_WRITE: begin
        // Sprite store and sound register writes have no readable effect here.
        if (ram_page) begin
          dec.ram_we   = 1'b1;
          dec.boot_set = (a == abad_pkg::ADDR_BOOT) && (write_data == abad_pkg::BOOT_MARK);
        end else if (a == abad_pkg::ADDR_IRQ_EN) begin
          dec.irq_en_we = 1'b1;
        end
      end
      abad_pkg::FUNC_PORT_OUT: begin
        dec.vec_we = 1'b1;
      end
      default: begin
        dec.read_const = abad_pkg::OPEN_BUS;
      end
    endcase
  end

endmodule

// ===== rtl/core/arcade_bus_address_decoder.sv =====
// Top level of the arcade bus address decoder: handshake, state and work RAM.
//
//  channel | direction | tdata (low bit up)                              | tuser
//  in_     | slave     | address, write_data, buttons, zero pad (32 b)   | func
//  out_    | master    | read_data, rom_address, irq_enabled,            | rom_hit
//          |           | irq_vector_out, booted, zero pad (40 b)         |
//  cfg_    | write     | cfg_wdata: dip_switch (8 b), taken when cfg_we  | -
//
// One word is accepted per cycle while in_tready is high; its result appears in
// the output register on the following cycle, the read of the work RAM being
// registered at the same edge. A write to RAM lands at the acceptance edge, so
// the read issued by the next word already sees it.
// After reset the work RAM is swept to zero, one entry per cycle, over all 4096
// entries; in_tready stays low during the sweep while configuration writes are
// still taken. When the output register is full and not taken, input stalls.
module arcade_bus_address_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // address, write_data, buttons from bit 0 up
  input  logic [abad_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // read_data, rom_address, irq_enabled, irq_vector_out, booted from bit 0 up
  output logic [abad_pkg::OUT_TDATA_W-1:0] out_tdata,
  // rom_hit
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  abad_pkg::state_t state_r, state_nxt;
  logic [abad_pkg::RAM_AW-1:0] clr_idx_r, clr_idx_nxt;

  logic [7:0] dip_r;
  logic       irq_en_r;
  logic [7:0] vec_r;
  logic       booted_r;

  logic        out_valid_r;
  logic        rom_hit_r;
  logic [15:0] rom_addr_r;
  logic        sel_ram_r;
  logic [7:0]  rd_const_r;

  abad_pkg::dec_t dec;
  logic           accept;
  logic           clearing;

  logic                        ram_we;
  logic [abad_pkg::RAM_AW-1:0] ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [7:0]                  ram_rdata;

  abad_decode u_decode (
    .func       (in_tuser),
    .address    (in_tdata[15:0]),
    .write_data (in_tdata[23:16]),
    .buttons    (in_tdata[30:24]),
    .dip_switch (dip_r),
    .dec        (dec)
  );

  assign clearing  = (state_r == abad_pkg::ST_CLEAR);
  assign in_tready = !clearing && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // The sweep owns the write port until it finishes.
  assign ram_we    = clearing || (accept && dec.ram_we);
  assign ram_waddr = clearing ? clr_idx_r : dec.ram_addr;
  assign ram_wdata = clearing ? 8'h00 : in_tdata[23:16];

  abad_ram #(
    .DEPTH (abad_pkg::RAM_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && dec.ram_read),
    .raddr (dec.ram_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      abad_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + abad_pkg::RAM_AW'(1);
        if (clr_idx_r == abad_pkg::RAM_AW'(abad_pkg::RAM_DEPTH - 1)) begin
          state_nxt = abad_pkg::ST_RUN;
        end
      end
      abad_pkg::ST_RUN: begin
        state_nxt = abad_pkg::ST_RUN;
      end
      default: begin
        state_nxt = abad_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abad_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      dip_r       <= 8'hFF;
      irq_en_r    <= 1'b0;
      vec_r       <= 8'h00;
      booted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (cfg_we) begin
        dip_r <= cfg_wdata;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
        if (dec.irq_en_we) begin
          irq_en_r <= in_tdata[16];
        end
        if (dec.vec_we) begin
          vec_r <= in_tdata[23:16];
        end
        if (dec.boot_set) begin
          booted_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the state registers change only when a word is accepted,
  // which also reloads this register, so they can be shown directly.
  always_ff @(posedge clk) begin
    if (accept) begin
      rom_hit_r  <= dec.rom_hit;
      rom_addr_r <= dec.rom_address;
      sel_ram_r  <= dec.ram_read;
      rd_const_r <= dec.read_const;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = rom_hit_r;
  assign out_tdata  = {6'b0, booted_r, vec_r, irq_en_r, rom_addr_r,
                       (sel_ram_r ? ram_rdata : rd_const_r)};

endmodule

// ===== rtl/core/abad_checker.sv =====
// Port-level checks for the arcade bus address decoder, bound to the top level.
module abad_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic [abad_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [1:0]                        in_tuser,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [abad_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  a_rom_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == abad_pkg::OPEN_BUS)
    else $error("ROM access does not show open-bus read data");

  a_rom_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:8] == 16'h0000)
    else $error("ROM address set without a ROM access");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word gave no result on the next cycle");

  a_vector_latch: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == abad_pkg::FUNC_PORT_OUT
    |=> out_tdata[32:25] == $past(in_tdata[23:16]))
    else $error("port output did not latch the interrupt vector");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind arcade_bus_address_decoder abad_checker u_abad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
